@@ src/interval_set_membership_top_assert.svh @@
// assertion macros for the interval set membership block
// used by the checker, expects clk and rst in scope
`ifndef INTERVAL_SET_MEMBERSHIP_TOP_ASSERT_SVH
`define INTERVAL_SET_MEMBERSHIP_TOP_ASSERT_SVH

// same-cycle implication
`define ISETM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval set membership check failed");

// next-cycle implication
`define ISETM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval set membership check failed");

`endif

@@ src/isetm_pkg.sv @@
// shared types and sizes for the interval set membership block
// no dependencies
package isetm_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int VALUE_BITS    = 48;
  localparam int IDX_BITS      = $clog2(MAX_INTERVALS);
  localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_BITS-1:0]   count_t;
  typedef logic [IDX_BITS-1:0]   index_t;

  localparam count_t FULL_COUNT = count_t'(MAX_INTERVALS);

  typedef struct packed {
    value_t lo;
    value_t hi;
  } entry_t;

  typedef struct packed {
    logic below;
    logic above;
    logic lo_less;
    logic hi_more;
    logic member;
  } cmp_t;

endpackage

@@ src/isetm_cmp.sv @@
// shared compare unit: one stored interval against the working bounds
// depends on isetm_pkg
module isetm_cmp (
  input  isetm_pkg::entry_t entry,
  input  isetm_pkg::value_t lo,
  input  isetm_pkg::value_t hi,
  input  isetm_pkg::value_t qv,
  output isetm_pkg::cmp_t   res
);

  always_comb begin
    res.below   = entry.hi < lo;
    res.above   = entry.lo > hi;
    res.lo_less = entry.lo < lo;
    res.hi_more = entry.hi > hi;
    res.member  = (entry.lo <= qv) && (qv <= entry.hi);
  end

endmodule

@@ src/interval_set_membership_top.sv @@
// Sorted table of up to 64 disjoint closed intervals with merge on insert and
// membership query; one item at a time, one result per item. A query walks the
// stored entries once through the single compare unit, one entry a cycle. An
// insert walks the table once to widen the new interval, then again to copy the
// rebuilt table from one bank to the other. A dropped insert on a full table
// stops after the first walk. Two table banks of 64 entries swap on each stored
// insert; no clearing pass after reset. Depends on isetm_pkg and isetm_cmp.
module interval_set_membership_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic [isetm_pkg::VALUE_BITS-1:0]   start_value,
  input  logic [isetm_pkg::VALUE_BITS-1:0]   end_value,
  input  logic [isetm_pkg::VALUE_BITS-1:0]   query_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               is_member,
  output logic                               table_overflow
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  isetm_pkg::entry_t bank0 [isetm_pkg::MAX_INTERVALS];
  isetm_pkg::entry_t bank1 [isetm_pkg::MAX_INTERVALS];
  isetm_pkg::entry_t rd0, rd1, cur_entry;

  logic [2:0]        state, state_next;
  logic              op, op_next;
  isetm_pkg::value_t lo, lo_next, hi, hi_next, qv, qv_next;
  isetm_pkg::count_t n, n_next, ra, ra_next, w, w_next;
  isetm_pkg::count_t entry_count, entry_count_next;
  logic              rv, rv_next;
  logic              hits, hits_next;
  logic              placed, placed_next;
  logic              member, member_next;
  logic              ovf, ovf_next;
  logic              sel, sel_next;
  isetm_pkg::entry_t carry, carry_next;
  logic              out_valid_next, is_member_next, table_overflow_next;

  logic              we;
  isetm_pkg::index_t wa;
  isetm_pkg::entry_t wd;
  logic              issue, pass_done;
  isetm_pkg::cmp_t   cmp;

  assign cur_entry = sel ? rd1 : rd0;
  assign in_ready  = (state == S_IDLE);
  assign issue     = (ra != n);
  assign pass_done = !issue && !rv;

  isetm_cmp u_cmp (
    .entry (cur_entry),
    .lo    (lo),
    .hi    (hi),
    .qv    (qv),
    .res   (cmp)
  );

  always_ff @(posedge clk) begin
    rd0 <= bank0[ra[isetm_pkg::IDX_BITS-1:0]];
    rd1 <= bank1[ra[isetm_pkg::IDX_BITS-1:0]];
    if (we && !sel) begin
      bank1[wa] <= wd;
    end
    if (we && sel) begin
      bank0[wa] <= wd;
    end
  end

  always_comb begin
    state_next          = state;
    op_next             = op;
    lo_next             = lo;
    hi_next             = hi;
    qv_next             = qv;
    n_next              = n;
    ra_next             = ra;
    w_next              = w;
    rv_next             = 1'b0;
    hits_next           = hits;
    placed_next         = placed;
    member_next         = member;
    ovf_next            = ovf;
    sel_next            = sel;
    carry_next          = carry;
    entry_count_next    = entry_count;
    out_valid_next      = out_valid && !out_ready;
    is_member_next      = is_member;
    table_overflow_next = table_overflow;
    we                  = 1'b0;
    wa                  = w[isetm_pkg::IDX_BITS-1:0];
    wd                  = '{lo: lo, hi: hi};

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next     = operation;
          qv_next     = query_value;
          if (end_value < start_value) begin
            lo_next = end_value;
            hi_next = start_value;
          end else begin
            lo_next = start_value;
            hi_next = end_value;
          end
          n_next      = entry_count;
          ra_next     = '0;
          w_next      = '0;
          hits_next   = 1'b0;
          placed_next = 1'b0;
          member_next = 1'b0;
          ovf_next    = 1'b0;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          ra_next = ra + 1'b1;
          rv_next = 1'b1;
        end
        if (rv) begin
          if (op == isetm_pkg::OP_QUERY) begin
            if (cmp.member) begin
              member_next = 1'b1;
            end
          end else if (!cmp.below && !cmp.above) begin
            hits_next = 1'b1;
            if (cmp.lo_less) begin
              lo_next = cur_entry.lo;
            end
            if (cmp.hi_more) begin
              hi_next = cur_entry.hi;
            end
          end
        end
        if (pass_done) begin
          ra_next = '0;
          if (op == isetm_pkg::OP_QUERY) begin
            state_next = S_DONE;
          end else if (!hits && n >= isetm_pkg::FULL_COUNT) begin
            ovf_next   = 1'b1;
            state_next = S_DONE;
          end else begin
            state_next = S_COPY;
          end
        end
      end
      S_COPY: begin
        if (issue) begin
          ra_next = ra + 1'b1;
          rv_next = 1'b1;
        end
        if (rv) begin
          if (cmp.below) begin
            we     = 1'b1;
            wd     = cur_entry;
            w_next = w + 1'b1;
          end else if (cmp.above) begin
            we          = 1'b1;
            wd          = placed ? carry : '{lo: lo, hi: hi};
            carry_next  = cur_entry;
            placed_next = 1'b1;
            w_next      = w + 1'b1;
          end
        end
        if (pass_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        we               = 1'b1;
        wd               = placed ? carry : '{lo: lo, hi: hi};
        entry_count_next = w + 1'b1;
        sel_next         = !sel;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next      = 1'b1;
          is_member_next      = member;
          table_overflow_next = ovf;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      sel         <= 1'b0;
      out_valid   <= 1'b0;
      rv          <= 1'b0;
      ra          <= '0;
      n           <= '0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      sel         <= sel_next;
      out_valid   <= out_valid_next;
      rv          <= rv_next;
      ra          <= ra_next;
      n           <= n_next;
    end
  end

  always_ff @(posedge clk) begin
    op             <= op_next;
    lo             <= lo_next;
    hi             <= hi_next;
    qv             <= qv_next;
    w              <= w_next;
    hits           <= hits_next;
    placed         <= placed_next;
    member         <= member_next;
    ovf            <= ovf_next;
    carry          <= carry_next;
    is_member      <= is_member_next;
    table_overflow <= table_overflow_next;
  end

endmodule

@@ src/isetm_check.sv @@
// port-level checker for the interval set membership block, bound to the top
// depends on isetm_pkg and interval_set_membership_top_assert.svh
`include "interval_set_membership_top_assert.svh"

module isetm_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             operation,
  input logic [isetm_pkg::VALUE_BITS-1:0] start_value,
  input logic [isetm_pkg::VALUE_BITS-1:0] end_value,
  input logic [isetm_pkg::VALUE_BITS-1:0] query_value,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             is_member,
  input logic                             table_overflow
);

  // a held result beat stays valid and keeps its payload
  `ISETM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ISETM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({is_member, table_overflow}))

  // a result never reports both a hit and a dropped insert
  `ISETM_ASSERT_NOW(a_out_excl, out_valid, !(is_member && table_overflow))

  // a new result appears together with the return to idle
  `ISETM_ASSERT_NOW(a_out_rise_idle, $rose(out_valid), in_ready)

  // only one item in flight
  `ISETM_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule

bind interval_set_membership_top isetm_check u_isetm_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .operation      (operation),
  .start_value    (start_value),
  .end_value      (end_value),
  .query_value    (query_value),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .is_member      (is_member),
  .table_overflow (table_overflow)
);

@@ tb/sv/tb_interval_set_membership_top.sv @@
// testbench for interval_set_membership_top: inserts and membership queries under random idling,
// each result predicted by a small scoreboard class and checked in order
// depends on isetm_pkg and the interval_set_membership_top rtl
module tb_interval_set_membership_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef isetm_pkg::value_t value_t;

  localparam value_t VALUE_MAX       = '1;
  localparam value_t REGION_SPAN     = value_t'(18'h3FFFF);
  localparam int     HOLD_CYCLES     = 400;
  localparam int     DRAIN_CYCLES    = 200;
  localparam int     STALL_LIMIT     = 5000;
  localparam int     ITEMS_PER_PHASE = 340;

  typedef struct packed {
    logic member;
    logic overflow;
  } verdict_t;

  class interval_scoreboard;
    value_t   lows[isetm_pkg::MAX_INTERVALS];
    value_t   highs[isetm_pkg::MAX_INTERVALS];
    int       entries;
    verdict_t expected_q[$];
    int       mismatches, checked, inserts, queries, drops, absorbed, hits, peak;

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic op, value_t rs, value_t re, value_t qv);
      value_t   nl[isetm_pkg::MAX_INTERVALS];
      value_t   nh[isetm_pkg::MAX_INTERVALS];
      value_t   lo, hi;
      int       w, touched;
      logic     placed;
      verdict_t v;
      v = '0;
      if (op == isetm_pkg::OP_QUERY) begin
        queries++;
        for (int i = 0; i < entries; i++)
          if (lows[i] <= qv && qv <= highs[i]) v.member = 1'b1;
        if (v.member) hits++;
      end else begin
        inserts++;
        lo = (re < rs) ? re : rs;
        hi = (re < rs) ? rs : re;
        touched = 0;
        w = 0;
        placed = 1'b0;
        // widen by every stored interval that overlaps or shares an endpoint
        for (int i = 0; i < entries; i++) begin
          if (lows[i] <= hi && highs[i] >= lo) begin
            touched++;
            if (lows[i] < lo) lo = lows[i];
            if (highs[i] > hi) hi = highs[i];
          end
        end
        if (touched == 0 && entries >= isetm_pkg::MAX_INTERVALS) begin
          v.overflow = 1'b1;
          drops++;
        end else begin
          for (int i = 0; i < entries; i++) begin
            if (highs[i] < lo) begin
              nl[w] = lows[i];
              nh[w] = highs[i];
              w++;
            end else if (lows[i] > hi) begin
              if (!placed) begin
                nl[w] = lo;
                nh[w] = hi;
                w++;
                placed = 1'b1;
              end
              nl[w] = lows[i];
              nh[w] = highs[i];
              w++;
            end
          end
          if (!placed) begin
            nl[w] = lo;
            nh[w] = hi;
            w++;
          end
          lows = nl;
          highs = nh;
          entries = w;
          absorbed += touched;
          if (entries > peak) peak = entries;
        end
      end
      expected_q.push_back(v);
    endfunction

    function void check_result(logic member, logic overflow);
      verdict_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d with nothing expected: is_member=%0b table_overflow=%0b",
                   checked, member, overflow);
        return;
      end
      want = expected_q.pop_front();
      if (member !== want.member || overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d: is_member exp %0b got %0b, table_overflow exp %0b got %0b",
                   checked, want.member, member, want.overflow, overflow);
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   operation = isetm_pkg::OP_INSERT;
  value_t start_value = '0;
  value_t end_value = '0;
  value_t query_value = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   is_member;
  logic   table_overflow;

  interval_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  interval_set_membership_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .start_value    (start_value),
    .end_value      (end_value),
    .query_value    (query_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_member      (is_member),
    .table_overflow (table_overflow)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(is_member, table_overflow);
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("FAIL interval_set_membership_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic value_t rand_value();
    return value_t'({$urandom, $urandom});
  endfunction

  task automatic send_beat(input logic op, input value_t rs, input value_t re,
                           input value_t qv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    start_value <= rs;
    end_value <= re;
    query_value <= qv;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, rs, re, qv);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), '0);
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), VALUE_MAX);
    send_beat(isetm_pkg::OP_INSERT, VALUE_MAX, VALUE_MAX, rand_value());
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), VALUE_MAX);
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), VALUE_MAX - 1);
    send_beat(isetm_pkg::OP_INSERT, '0, '0, rand_value());
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), '0);
    // reversed bounds
    send_beat(isetm_pkg::OP_INSERT, 48'd200, 48'd100, rand_value());
    // adjacent only, stays separate
    send_beat(isetm_pkg::OP_INSERT, 48'd201, 48'd300, rand_value());
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), 48'd200);
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), 48'd201);
    // shared endpoints merge
    send_beat(isetm_pkg::OP_INSERT, 48'd300, 48'd400, rand_value());
    send_beat(isetm_pkg::OP_INSERT, 48'd50, 48'd100, rand_value());
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), 48'd45);
    // spans several stored intervals
    send_beat(isetm_pkg::OP_INSERT, 48'd40, 48'd500, rand_value());
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), 48'd40);
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), 48'd501);
    send_beat(isetm_pkg::OP_INSERT, 48'd40, 48'd500, rand_value());
    send_beat(isetm_pkg::OP_INSERT, 48'h5555_5555_5556, 48'h5555_5555_5555, rand_value());
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), 48'h5555_5555_5555);
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), 48'hAAAA_AAAA_AAAA);
    send_beat(isetm_pkg::OP_INSERT, 48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, rand_value());
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), 48'hAAAA_AAAA_AAAA);
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), 48'h7FFF_FFFF_FFFF);
  endtask

  // episodes around a random base: point fills that reach a full table, or
  // short overlapping intervals, with queries aimed at stored endpoints
  task automatic run_random(input int n_items);
    value_t base, a, b, q, t;
    int     sent, len, pick, k;
    logic   fill;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        base = '0;
      end else if (pick == 1) begin
        base = VALUE_MAX - REGION_SPAN;
      end else begin
        base = rand_value();
        if (base > VALUE_MAX - REGION_SPAN) base = VALUE_MAX - REGION_SPAN;
      end
      fill = ($urandom_range(0, 2) == 0);
      len = fill ? $urandom_range(90, 140) : $urandom_range(30, 70);
      for (int j = 0; j < len && sent < n_items; j++) begin
        a = rand_value();
        b = rand_value();
        q = rand_value();
        pick = $urandom_range(0, 99);
        if (pick < (fill ? 25 : 40)) begin
          if (sb.entries != 0 && $urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, sb.entries - 1);
            case ($urandom_range(0, 4))
              0: q = sb.lows[k] - 1;
              1: q = sb.lows[k];
              2: q = sb.highs[k];
              3: q = sb.highs[k] + 1;
              default: q = sb.lows[k] + ((sb.highs[k] - sb.lows[k]) >> 1);
            endcase
          end else if ($urandom_range(0, 9) < 8) begin
            q = base + $urandom_range(0, 4200);
          end
          send_beat(isetm_pkg::OP_QUERY, a, b, q);
        end else begin
          if (fill) begin
            a = base + 4 * $urandom_range(0, 1023);
            b = a;
          end else begin
            a = base + $urandom_range(0, 4096);
            b = a + $urandom_range(0, 96);
            if ($urandom_range(0, 3) == 0) begin
              t = a;
              a = b;
              b = t;
            end
          end
          send_beat(isetm_pkg::OP_INSERT, a, b, q);
        end
        sent++;
      end
      if ($urandom_range(0, 1) == 0 && sent < n_items) begin
        send_beat(isetm_pkg::OP_INSERT, base, base + REGION_SPAN, rand_value());
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 55;
    run_directed();
    run_random(ITEMS_PER_PHASE);

    // sender pauses until the block has answered everything
    wait_drained();
    send_idle_pct = 55;
    recv_idle_pct = 35;
    hold_requests = hold_requests + 1;
    run_random(ITEMS_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = hold_requests + 1;
    run_random(ITEMS_PER_PHASE);

    // whole value range, reversed, swallows the table
    send_beat(isetm_pkg::OP_INSERT, VALUE_MAX, '0, rand_value());
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), '0);
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), VALUE_MAX);
    send_beat(isetm_pkg::OP_QUERY, rand_value(), rand_value(), rand_value());
    send_beat(isetm_pkg::OP_INSERT, rand_value(), rand_value(), rand_value());

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d inserts (%0d dropped on a full table, %0d stored intervals merged), %0d queries",
             sb.inserts, sb.drops, sb.absorbed, sb.queries);
    $display("%0d queries inside the set, table peaked at %0d entries, %0d beats checked",
             sb.hits, sb.peak, sb.checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS interval_set_membership_top");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("FAIL interval_set_membership_top");
    end
    $finish;
  end

endmodule
